### design/ahfp_pkg.sv
package ahfp_pkg;

  // character codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ABORT = 8'h58;  // 'X'

  localparam logic        KIND_BYTE = 1'b0;
  localparam logic        KIND_TICK = 1'b1;
  localparam logic [15:0] TCNT_MAX  = 16'hFFFF;
  localparam int          FRAME_LEN_W = 7;

  typedef enum logic [2:0] {
    FS_IDLE     = 3'd0,
    FS_READING  = 3'd1,
    FS_COMPLETE = 3'd2,
    FS_FMT_ERR  = 3'd3,
    FS_CK_ERR   = 3'd4
  } frame_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_RMW,
    CTL_RESULT,
    CTL_RUN
  } ctl_e;

  typedef enum logic [1:0] {
    ACT_SINGLE,
    ACT_RMW,
    ACT_RUN
  } act_e;

  typedef enum logic {
    OP_MERGE,
    OP_LRC
  } op_e;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nib;
    logic       is_colon;
    logic       is_eol;
    logic       is_abort;
  } char_t;

  typedef struct packed {
    frame_e                 status;
    logic [7:0]             payload_byte;
    logic                   byte_valid;
    logic                   last;
    logic [7:0]             expected_lrc;
    logic [FRAME_LEN_W-1:0] frame_length;
  } result_t;

  function automatic char_t classify(logic [7:0] c);
    char_t r;
    r.is_hex   = 1'b0;
    r.nib      = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.is_hex = 1'b1;
      r.nib    = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.is_hex = 1'b1;
      r.nib    = c[3:0] + 4'd9;
    end
    r.is_colon = (c == CH_COLON);
    r.is_eol   = (c == CH_CR) || (c == CH_LF);
    r.is_abort = (c == CH_ABORT);
    return r;
  endfunction

  function automatic result_t single_res(frame_e st, logic [7:0] lrc);
    result_t r;
    r.status       = st;
    r.payload_byte = 8'd0;
    r.byte_valid   = 1'b0;
    r.last         = 1'b1;
    r.expected_lrc = lrc;
    r.frame_length = '0;
    return r;
  endfunction

endpackage

### design/ahfp_if.sv
interface ahfp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface ahfp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic       last;
  logic [7:0] expected_lrc;
  logic [6:0] frame_length;
  modport source (output valid, output status, output payload_byte, output byte_valid,
                  output last, output expected_lrc, output frame_length, input ready);
  modport sink (input valid, input status, input payload_byte, input byte_valid,
                input last, input expected_lrc, input frame_length, output ready);
endinterface

interface ahfp_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;
  modport source (output valid, output timeout_ticks, input ready);
  modport sink (input valid, input timeout_ticks, output ready);
endinterface

### design/ahfp_out_stage.sv
module ahfp_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  ahfp_pkg::result_t res_i,
  output logic             free_o,
  ahfp_out_if.source       out_o
);
  import ahfp_pkg::*;

  logic    valid_q;
  result_t data_q;

  assign free_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_o.valid        = valid_q;
  assign out_o.status       = data_q.status;
  assign out_o.payload_byte = data_q.payload_byte;
  assign out_o.byte_valid   = data_q.byte_valid;
  assign out_o.last         = data_q.last;
  assign out_o.expected_lrc = data_q.expected_lrc;
  assign out_o.frame_length = data_q.frame_length;

endmodule

### design/ascii_hex_frame_parser.sv
// ascii_hex_frame_parser: receives one serial character or one timer tick per input
// item and recognizes ':'-led frames of uppercase hex digit pairs closed by CR/LF
// (LRC checked) or 'X' (no check).
// channels: in_i (kind, rx_byte), out_o (one result item per step, or a run of
// payload bytes on completion), cfg_i (timeout_ticks write, always ready).
// result path: a tick or a plain character is staged in the result register, then
// loaded into the output register; the second digit of a pair and a checksum error
// first pass the read-modify-write state, since the byte store is read (registered
// read port) and, for a digit, merged and written back.
// a completed frame streams out at one byte per cycle while the receiver takes the
// bytes, paced by the single read port of the byte store.
// input: an item is taken only while the control is idle, so after the previous
// result is loaded, and while that result may still wait in the output register.
// reset: parser idle, counters and sum zero, timeout disabled; the byte store is
// not cleared and is only read at entries written in the current frame.
// when the receiver stalls, the output register holds and the control holds its
// staged result (or its run position) until space frees up.
module ascii_hex_frame_parser #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ahfp_in_if.sink     in_i,
  ahfp_cfg_if.sink    cfg_i,
  ahfp_out_if.source  out_o
);
  import ahfp_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int DW = CW + 1;

  ctl_e            ctl_q, ctl_d;
  frame_e          frame_q, frame_d;
  logic [DW-1:0]   digit_q, digit_d;
  logic [7:0]      sum_q, sum_d;
  logic [CW-1:0]   stored_q, stored_d;
  logic [15:0]     tcnt_q, tcnt_d;
  logic            trun_q, trun_d;
  logic [15:0]     tticks_q;
  op_e             op_q, op_d;
  logic [3:0]      nib_q, nib_d;
  logic [CW-1:0]   run_n_q, run_n_d;
  logic [AW-1:0]   run_k_q, run_k_d;
  result_t         res_q, res_d;

  logic [7:0]      mem [BUFFER_DEPTH];
  logic [7:0]      rdata_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wdata;

  logic            accept;
  char_t           ch;
  frame_e          fs;
  logic [15:0]     tcnt_inc;
  logic [CW-1:0]   stored_m1;
  logic [AW-1:0]   last_addr;
  logic            full;
  logic            digit_even;
  logic            run_last;
  logic [7:0]      merged;
  act_e            act;
  logic            out_load, out_free;
  result_t         out_res;

  assign in_i.ready  = (ctl_q == CTL_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign ch         = classify(in_i.rx_byte);
  assign fs         = (frame_q == FS_COMPLETE || frame_q == FS_FMT_ERR ||
                       frame_q == FS_CK_ERR) ? FS_IDLE : frame_q;
  assign tcnt_inc   = (tcnt_q == TCNT_MAX) ? tcnt_q : tcnt_q + 16'd1;
  assign stored_m1  = stored_q - CW'(1);
  assign last_addr  = stored_m1[AW-1:0];
  assign full       = stored_q >= CW'(BUFFER_DEPTH);
  assign digit_even = !digit_q[0];
  assign run_last   = (CW'(run_k_q) + CW'(1)) == run_n_q;
  assign merged     = rdata_q | {4'd0, nib_q};

  // datapath and memory access
  always_comb begin
    frame_d   = frame_q;
    digit_d   = digit_q;
    sum_d     = sum_q;
    stored_d  = stored_q;
    tcnt_d    = tcnt_q;
    trun_d    = trun_q;
    op_d      = op_q;
    nib_d     = nib_q;
    run_n_d   = run_n_q;
    run_k_d   = run_k_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = 8'd0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    act       = ACT_SINGLE;
    out_load  = 1'b0;
    out_res   = res_q;

    unique case (ctl_q)
      CTL_IDLE: begin
        if (accept) begin
          frame_d = fs;
          if (in_i.kind == KIND_TICK) begin
            if (trun_q) begin
              tcnt_d = tcnt_inc;
              if (tticks_q != 16'd0 && tcnt_inc >= tticks_q) begin
                frame_d = FS_IDLE;
                trun_d  = 1'b0;
              end
            end
          end else if (fs == FS_IDLE) begin
            if (ch.is_colon) begin
              frame_d  = FS_READING;
              digit_d  = '0;
              sum_d    = 8'd0;
              stored_d = '0;
              tcnt_d   = 16'd0;
              trun_d   = 1'b1;
            end
          end else if (ch.is_hex) begin
            if (digit_even) begin
              if (full) begin
                frame_d = FS_FMT_ERR;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = stored_q[AW-1:0];
                mem_wdata = {ch.nib, 4'd0};
                stored_d  = stored_q + CW'(1);
                digit_d   = digit_q + DW'(1);
              end
            end else begin
              // low nibble: read back the open byte and merge next cycle
              mem_re    = 1'b1;
              mem_raddr = last_addr;
              nib_d     = ch.nib;
              op_d      = OP_MERGE;
              act       = ACT_RMW;
            end
          end else if (ch.is_eol) begin
            if (digit_q >= DW'(4) && digit_even) begin
              if (sum_q != 8'd0) begin
                frame_d   = FS_CK_ERR;
                mem_re    = 1'b1;
                mem_raddr = last_addr;
                op_d      = OP_LRC;
                act       = ACT_RMW;
              end else begin
                // lrc byte dropped from the run
                frame_d   = FS_COMPLETE;
                stored_d  = stored_m1;
                run_n_d   = stored_m1;
                run_k_d   = '0;
                mem_re    = 1'b1;
                mem_raddr = '0;
                act       = ACT_RUN;
              end
            end else begin
              frame_d = FS_FMT_ERR;
            end
          end else if (ch.is_abort) begin
            if (digit_q >= DW'(2) && digit_even) begin
              frame_d   = FS_COMPLETE;
              run_n_d   = stored_q;
              run_k_d   = '0;
              mem_re    = 1'b1;
              mem_raddr = '0;
              act       = ACT_RUN;
            end
          end else begin
            frame_d = FS_IDLE;
          end
          if (act == ACT_SINGLE) begin
            res_d = single_res(frame_d, 8'd0);
          end
        end
      end
      CTL_RMW: begin
        if (op_q == OP_MERGE) begin
          mem_we    = 1'b1;
          mem_waddr = last_addr;
          mem_wdata = merged;
          sum_d     = sum_q + merged;
          digit_d   = digit_q + DW'(1);
          res_d     = single_res(frame_q, 8'd0);
        end else begin
          // lrc that zeroes the sum of the data bytes
          res_d = single_res(frame_q, rdata_q - sum_q);
        end
      end
      CTL_RESULT: begin
        out_load = out_free;
      end
      CTL_RUN: begin
        out_res.status       = FS_COMPLETE;
        out_res.payload_byte = rdata_q;
        out_res.byte_valid   = 1'b1;
        out_res.last         = run_last;
        out_res.expected_lrc = 8'd0;
        out_res.frame_length = FRAME_LEN_W'(run_n_q);
        if (out_free) begin
          out_load = 1'b1;
          if (!run_last) begin
            mem_re    = 1'b1;
            mem_raddr = run_k_q + AW'(1);
            run_k_d   = run_k_q + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control next state
  always_comb begin
    ctl_d = ctl_q;
    unique case (ctl_q)
      CTL_IDLE: begin
        if (accept) begin
          unique case (act)
            ACT_RMW: ctl_d = CTL_RMW;
            ACT_RUN: ctl_d = CTL_RUN;
            default: ctl_d = CTL_RESULT;
          endcase
        end
      end
      CTL_RMW: ctl_d = CTL_RESULT;
      CTL_RESULT: begin
        if (out_free) begin
          ctl_d = CTL_IDLE;
        end
      end
      CTL_RUN: begin
        if (out_free && run_last) begin
          ctl_d = CTL_IDLE;
        end
      end
      default: ctl_d = CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q    <= CTL_IDLE;
      frame_q  <= FS_IDLE;
      digit_q  <= '0;
      sum_q    <= 8'd0;
      stored_q <= '0;
      tcnt_q   <= 16'd0;
      trun_q   <= 1'b0;
      tticks_q <= 16'd0;
      run_n_q  <= '0;
      run_k_q  <= '0;
    end else begin
      ctl_q    <= ctl_d;
      frame_q  <= frame_d;
      digit_q  <= digit_d;
      sum_q    <= sum_d;
      stored_q <= stored_d;
      tcnt_q   <= tcnt_d;
      trun_q   <= trun_d;
      run_n_q  <= run_n_d;
      run_k_q  <= run_k_d;
      if (cfg_i.valid) begin
        tticks_q <= cfg_i.timeout_ticks;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    nib_q <= nib_d;
    res_q <= res_d;
  end

  // byte store, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  ahfp_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .res_i  (out_res),
    .free_o (out_free),
    .out_o  (out_o)
  );

  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= CW'(BUFFER_DEPTH))
    else $error("stored byte count beyond buffer depth");

  a_odd_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digit_q[0] |-> stored_q != '0)
    else $error("open nibble without a stored byte");

  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_q == CTL_RUN |-> CW'(run_k_q) < run_n_q)
    else $error("run position past frame length");

  a_tick_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.kind == KIND_TICK |=> ctl_q == CTL_RESULT)
    else $error("tick item did not stage a single result");

endmodule
